>>> src/tcpr_pkg.sv
package tcpr_pkg;

    localparam logic [7:0] T_IAC  = 8'hFF;
    localparam logic [7:0] T_SB   = 8'hFA;
    localparam logic [7:0] T_SE   = 8'hF0;
    localparam logic [7:0] T_WILL = 8'hFB;
    localparam logic [7:0] T_WONT = 8'hFC;
    localparam logic [7:0] T_DO   = 8'hFD;
    localparam logic [7:0] T_DONT = 8'hFE;
    localparam logic [7:0] OPT_COM = 8'h2C;

    localparam logic [7:0] C_BAUD    = 8'h01;
    localparam logic [7:0] C_DSIZE   = 8'h02;
    localparam logic [7:0] C_PARITY  = 8'h03;
    localparam logic [7:0] C_STOP    = 8'h04;
    localparam logic [7:0] C_CONTROL = 8'h05;
    localparam logic [7:0] C_NOTIFY  = 8'h06;
    localparam logic [7:0] C_FLOW    = 8'h07;
    localparam logic [7:0] C_LMASK   = 8'h0A;
    localparam logic [7:0] C_MMASK   = 8'h0B;
    localparam logic [7:0] C_PURGE   = 8'h0C;
    localparam logic [7:0] REPLY_OFS = 8'h64;

    localparam logic [1:0] F_BYTE  = 2'd0;
    localparam logic [1:0] F_OPEN  = 2'd1;
    localparam logic [1:0] F_CLOSE = 2'd2;

    localparam logic [1:0] D_SERIAL = 2'd0;
    localparam logic [1:0] D_NET    = 2'd1;
    localparam logic [1:0] D_STATUS = 2'd2;

    localparam int SUB_KEEP = 6;
    localparam int OPEN_LEN = 35;

    typedef enum logic [2:0] {
        PS_NORMAL = 3'd0,
        PS_IAC    = 3'd1,
        PS_NEG    = 3'd2,
        PS_SUB    = 3'd3,
        PS_SUBIAC = 3'd4
    } t_parse;

    typedef enum logic [2:0] {
        K_STATUS = 3'd0,
        K_DATA   = 3'd1,
        K_OPT    = 3'd2,
        K_SUB    = 3'd3,
        K_OPEN   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_VAL  = 2'd1,
        PH_ESC  = 2'd2,
        PH_TAIL = 2'd3
    } t_phase;

    typedef struct packed {
        logic        dtr;
        logic        rts;
        logic        brk;
        logic [31:0] baud;
        logic [3:0]  bits;
        logic [1:0]  par;
        logic [1:0]  stop;
        logic        pg_rx;
        logic        pg_tx;
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [31:0] value;
        logic        wide;
        t_status     status;
    } t_job;

    function automatic logic [7:0] open_byte(input logic [5:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            6'd0, 6'd3, 6'd6, 6'd9, 6'd12, 6'd15, 6'd18: b = T_IAC;
            6'd1, 6'd4, 6'd10, 6'd16: b = T_WILL;
            6'd7, 6'd13, 6'd19: b = T_DO;
            6'd2:  b = 8'h01;
            6'd5, 6'd8: b = 8'h03;
            6'd11, 6'd14: b = 8'h00;
            6'd17, 6'd20: b = OPT_COM;
            6'd21, 6'd26, 6'd28, 6'd33: b = T_IAC;
            6'd22, 6'd29: b = T_SB;
            6'd23, 6'd30: b = OPT_COM;
            6'd24: b = 8'h6A;
            6'd31: b = 8'h6B;
            6'd25, 6'd32: b = 8'h00;
            6'd27, 6'd34: b = T_SE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> src/tcpr_if.sv
interface tcpr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;
    modport source (output valid, func, rx_byte, input ready);
    modport sink (input valid, func, rx_byte, output ready);
endinterface

interface tcpr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_dest;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        dtr_on;
    logic        rts_on;
    logic        break_on;
    logic [31:0] baud_rate;
    logic [3:0]  data_bits;
    logic [1:0]  parity_code;
    logic [1:0]  stop_bits;
    logic        purge_rx;
    logic        purge_tx;
    modport source (output valid, out_dest, out_byte, out_last, dtr_on, rts_on, break_on,
                    baud_rate, data_bits, parity_code, stop_bits, purge_rx, purge_tx,
                    input ready);
    modport sink (input valid, out_dest, out_byte, out_last, dtr_on, rts_on, break_on,
                  baud_rate, data_bits, parity_code, stop_bits, purge_rx, purge_tx,
                  output ready);
endinterface

>>> src/tcpr_front.sv
module tcpr_front
    import tcpr_pkg::*;
#(
    parameter int SUB_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcpr_in_if.sink   i_net,
    input  logic      i_job_ready,
    output logic      o_job_valid,
    output t_job      o_job
);
    localparam int CW = $clog2(SUB_DEPTH + 1);

    t_parse      r_state, n_state;
    logic [7:0]  r_pend, n_pend;
    logic [7:0]  r_sub [SUB_KEEP];
    logic [CW-1:0] r_cnt, n_cnt;
    logic        r_dtr, n_dtr, r_rts, n_rts, r_brk, n_brk;
    logic [7:0]  r_lmask, n_lmask, r_mmask, n_mmask;
    logic [31:0] r_baud, n_baud;
    logic [3:0]  r_bits, n_bits;
    logic [1:0]  r_par, n_par, r_stop, n_stop;
    logic        push;
    logic        acc;
    logic [7:0]  v;

    assign i_net.ready = i_job_ready;
    assign acc         = i_net.valid & i_job_ready;
    assign o_job_valid = i_net.valid;
    assign v           = i_net.rx_byte;

    always_comb begin
        n_state = r_state;
        if (i_net.func == F_BYTE) begin
            unique case (r_state)
                PS_IAC: begin
                    if (v == T_DO || v == T_DONT || v == T_WILL || v == T_WONT) begin
                        n_state = PS_NEG;
                    end else if (v == T_SB) begin
                        n_state = PS_SUB;
                    end else begin
                        n_state = PS_NORMAL;
                    end
                end
                PS_NEG:    n_state = PS_NORMAL;
                PS_SUB:    n_state = (v == T_IAC) ? PS_SUBIAC : PS_SUB;
                PS_SUBIAC: n_state = (v == T_IAC) ? PS_SUB : PS_NORMAL;
                default:   n_state = (v == T_IAC) ? PS_IAC : PS_NORMAL;
            endcase
        end else if (i_net.func == F_OPEN || i_net.func == F_CLOSE) begin
            n_state = PS_NORMAL;
        end
    end

    always_comb begin
        logic [7:0]  a;
        logic [31:0] br;
        logic        has3;
        logic        has6;
        logic        pg_rx;
        logic        pg_tx;
        logic        loc;
        logic        rem;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_dtr   = r_dtr;
        n_rts   = r_rts;
        n_brk   = r_brk;
        n_lmask = r_lmask;
        n_mmask = r_mmask;
        n_baud  = r_baud;
        n_bits  = r_bits;
        n_par   = r_par;
        n_stop  = r_stop;
        push    = 1'b0;
        pg_rx   = 1'b0;
        pg_tx   = 1'b0;
        has3    = (r_cnt >= CW'(3));
        has6    = (r_cnt >= CW'(6));
        a       = has3 ? r_sub[2] : 8'h00;
        br      = {r_sub[2], r_sub[3], r_sub[4], r_sub[5]};
        loc     = (v == 8'h00) || (v == 8'h01) || (v == 8'h03) || (v == OPT_COM);
        rem     = (v == 8'h00) || (v == 8'h03) || (v == OPT_COM);
        o_job.kind  = K_STATUS;
        o_job.b0    = 8'h00;
        o_job.b1    = 8'h00;
        o_job.value = 32'd0;
        o_job.wide  = 1'b0;

        case (i_net.func)
            F_BYTE: begin
                unique case (r_state)
                    PS_IAC: begin
                        if (v == T_IAC) begin
                            o_job.kind = K_DATA;
                            o_job.b0   = T_IAC;
                        end else if (v == T_DO || v == T_DONT || v == T_WILL
                                     || v == T_WONT) begin
                            n_pend = v;
                        end else if (v == T_SB) begin
                            n_cnt = '0;
                        end
                    end
                    PS_NEG: begin
                        o_job.kind = K_OPT;
                        o_job.b1   = v;
                        if (r_pend == T_DO) begin
                            o_job.b0 = loc ? T_WILL : T_WONT;
                        end else if (r_pend == T_WILL) begin
                            o_job.b0 = rem ? T_DO : T_DONT;
                        end else if (r_pend == T_DONT) begin
                            o_job.b0 = T_WONT;
                        end else if (r_pend == T_WONT) begin
                            o_job.b0 = T_DONT;
                        end else begin
                            o_job.kind = K_STATUS;
                        end
                    end
                    PS_SUB: begin
                        push = (v != T_IAC);
                    end
                    PS_SUBIAC: begin
                        if (v == T_IAC) begin
                            push = 1'b1;
                        end else if (v == T_SE && r_cnt >= CW'(2)
                                     && r_sub[0] == OPT_COM) begin
                            o_job.kind = K_SUB;
                            o_job.b0   = r_sub[1] + REPLY_OFS;
                            case (r_sub[1])
                                C_BAUD: begin
                                    if (has6 && br != 32'd0) begin
                                        n_baud = br;
                                        pg_rx  = 1'b1;
                                        pg_tx  = 1'b1;
                                    end
                                    o_job.value = n_baud;
                                    o_job.wide  = 1'b1;
                                end
                                C_DSIZE: begin
                                    if (has3 && a >= 8'd5 && a <= 8'd8) begin
                                        n_bits = a[3:0];
                                        pg_rx  = 1'b1;
                                        pg_tx  = 1'b1;
                                    end
                                    o_job.value = {28'd0, n_bits};
                                end
                                C_PARITY: begin
                                    if (has3 && a >= 8'd1 && a <= 8'd3) begin
                                        n_par = a[1:0];
                                        pg_rx = 1'b1;
                                        pg_tx = 1'b1;
                                    end
                                    o_job.value = {30'd0, n_par};
                                end
                                C_STOP: begin
                                    if (has3 && (a == 8'd1 || a == 8'd2)) begin
                                        n_stop = a[1:0];
                                        pg_rx  = 1'b1;
                                        pg_tx  = 1'b1;
                                    end
                                    o_job.value = {30'd0, n_stop};
                                end
                                C_CONTROL: begin
                                    if (!has3) begin
                                        o_job.kind = K_STATUS;
                                    end else begin
                                        case (a)
                                            8'd0, 8'd1, 8'd2, 8'd3: o_job.value = 32'd1;
                                            8'd4: o_job.value = r_brk ? 32'd5 : 32'd6;
                                            8'd5: begin n_brk = 1'b1; o_job.value = 32'd5; end
                                            8'd6: begin n_brk = 1'b0; o_job.value = 32'd6; end
                                            8'd7: o_job.value = r_dtr ? 32'd8 : 32'd9;
                                            8'd8: begin n_dtr = 1'b1; o_job.value = 32'd8; end
                                            8'd9: begin n_dtr = 1'b0; o_job.value = 32'd9; end
                                            8'd10: o_job.value = r_rts ? 32'd11 : 32'd12;
                                            8'd11: begin n_rts = 1'b1; o_job.value = 32'd11; end
                                            8'd12: begin n_rts = 1'b0; o_job.value = 32'd12; end
                                            default: o_job.kind = K_STATUS;
                                        endcase
                                    end
                                end
                                C_NOTIFY, C_FLOW: o_job.value = 32'd0;
                                C_LMASK: begin
                                    if (has3) n_lmask = a;
                                    o_job.value = {24'd0, n_lmask};
                                end
                                C_MMASK: begin
                                    if (has3) n_mmask = a;
                                    o_job.value = {24'd0, n_mmask};
                                end
                                C_PURGE: begin
                                    if (has3) begin
                                        pg_rx = (a == 8'd1) || (a == 8'd3);
                                        pg_tx = (a == 8'd2) || (a == 8'd3);
                                        o_job.value = {24'd0, a};
                                    end else begin
                                        o_job.kind = K_STATUS;
                                    end
                                end
                                default: o_job.kind = K_STATUS;
                            endcase
                        end
                    end
                    default: begin
                        if (v != T_IAC) begin
                            o_job.kind = K_DATA;
                            o_job.b0   = v;
                        end
                    end
                endcase
            end
            F_OPEN: begin
                n_pend     = 8'h00;
                n_cnt      = '0;
                pg_rx      = 1'b1;
                pg_tx      = 1'b1;
                o_job.kind = K_OPEN;
            end
            F_CLOSE: begin
                n_pend = 8'h00;
                n_cnt  = '0;
                n_dtr  = 1'b0;
                n_rts  = 1'b0;
                pg_rx  = 1'b1;
                pg_tx  = 1'b1;
            end
            default: ;
        endcase

        if (push && r_cnt < CW'(SUB_DEPTH)) begin
            n_cnt = r_cnt + CW'(1);
        end

        o_job.status = '{dtr: n_dtr, rts: n_rts, brk: n_brk, baud: n_baud, bits: n_bits,
                         par: n_par, stop: n_stop, pg_rx: pg_rx, pg_tx: pg_tx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_NORMAL;
            r_pend  <= 8'h00;
            r_cnt   <= '0;
            r_dtr   <= 1'b0;
            r_rts   <= 1'b0;
            r_brk   <= 1'b0;
            r_lmask <= 8'h00;
            r_mmask <= 8'hFF;
            r_baud  <= 32'd115200;
            r_bits  <= 4'd8;
            r_par   <= 2'd1;
            r_stop  <= 2'd1;
        end else if (acc) begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_dtr   <= n_dtr;
            r_rts   <= n_rts;
            r_brk   <= n_brk;
            r_lmask <= n_lmask;
            r_mmask <= n_mmask;
            r_baud  <= n_baud;
            r_bits  <= n_bits;
            r_par   <= n_par;
            r_stop  <= n_stop;
        end
    end

    // only the leading bytes of a subnegotiation are ever decoded; keep those
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SUB_KEEP; k++) begin
            if (acc && push && r_cnt == CW'(k)) begin
                r_sub[k] <= v;
            end
        end
    end

endmodule

>>> src/tcpr_queue.sv
module tcpr_queue
    import tcpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push,
    output logic o_push_ready,
    output logic o_head_valid,
    output t_job o_head,
    input  logic i_pop
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_push_ready = (r_cnt != 2'd2);
    assign push         = i_push_valid & o_push_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

endmodule

>>> src/tcpr_back.sv
module tcpr_back
    import tcpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_pop,
    tcpr_out_if.source o_res
);
    t_phase     r_ph, n_ph;
    logic [5:0] r_idx, n_idx;
    logic       r_vld;
    logic [1:0] r_dest, dest;
    logic [7:0] r_byte, byte_q;
    logic       r_last, last;
    t_status    r_st;
    logic       adv;
    logic [7:0] vb;
    logic       vlast;

    assign adv   = i_job_valid & (~r_vld | o_res.ready);
    assign o_pop = adv & last;

    always_comb begin
        if (i_job.wide) begin
            case (r_idx[1:0])
                2'd0:    vb = i_job.value[31:24];
                2'd1:    vb = i_job.value[23:16];
                2'd2:    vb = i_job.value[15:8];
                default: vb = i_job.value[7:0];
            endcase
        end else begin
            vb = i_job.value[7:0];
        end
        vlast = i_job.wide ? (r_idx[1:0] == 2'd3) : 1'b1;
    end

    // next position within the burst
    always_comb begin
        n_ph  = r_ph;
        n_idx = r_idx + 6'd1;
        if (last) begin
            n_ph  = PH_HEAD;
            n_idx = 6'd0;
        end else if (i_job.kind == K_SUB) begin
            unique case (r_ph)
                PH_HEAD: if (r_idx == 6'd3) begin
                    n_ph  = PH_VAL;
                    n_idx = 6'd0;
                end
                PH_VAL: begin
                    if (vb == T_IAC) begin
                        n_ph  = PH_ESC;
                        n_idx = r_idx;
                    end else if (vlast) begin
                        n_ph  = PH_TAIL;
                        n_idx = 6'd0;
                    end
                end
                PH_ESC: begin
                    if (vlast) begin
                        n_ph  = PH_TAIL;
                        n_idx = 6'd0;
                    end else begin
                        n_ph = PH_VAL;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        dest   = D_NET;
        byte_q = 8'h00;
        last   = 1'b0;
        unique case (i_job.kind)
            K_DATA: begin
                dest   = D_SERIAL;
                byte_q = i_job.b0;
                last   = 1'b1;
            end
            K_OPT: begin
                last = (r_idx == 6'd2);
                case (r_idx[1:0])
                    2'd0:    byte_q = T_IAC;
                    2'd1:    byte_q = i_job.b0;
                    default: byte_q = i_job.b1;
                endcase
            end
            K_OPEN: begin
                byte_q = open_byte(r_idx);
                last   = (r_idx == 6'(OPEN_LEN - 1));
            end
            K_SUB: begin
                unique case (r_ph)
                    PH_HEAD: begin
                        case (r_idx[1:0])
                            2'd0:    byte_q = T_IAC;
                            2'd1:    byte_q = T_SB;
                            2'd2:    byte_q = OPT_COM;
                            default: byte_q = i_job.b0;
                        endcase
                    end
                    PH_VAL: byte_q = vb;
                    PH_ESC: byte_q = T_IAC;
                    default: begin
                        byte_q = (r_idx == 6'd0) ? T_IAC : T_SE;
                        last   = (r_idx == 6'd1);
                    end
                endcase
            end
            default: begin
                dest = D_STATUS;
                last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_ph  <= PH_HEAD;
            r_idx <= 6'd0;
        end else begin
            if (adv) begin
                r_vld <= 1'b1;
                r_ph  <= n_ph;
                r_idx <= n_idx;
            end else if (o_res.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dest <= dest;
            r_byte <= byte_q;
            r_last <= last;
            r_st   <= i_job.status;
        end
    end

    assign o_res.valid       = r_vld;
    assign o_res.out_dest    = r_dest;
    assign o_res.out_byte    = r_byte;
    assign o_res.out_last    = r_last;
    assign o_res.dtr_on      = r_st.dtr;
    assign o_res.rts_on      = r_st.rts;
    assign o_res.break_on    = r_st.brk;
    assign o_res.baud_rate   = r_st.baud;
    assign o_res.data_bits   = r_st.bits;
    assign o_res.parity_code = r_st.par;
    assign o_res.stop_bits   = r_st.stop;
    assign o_res.purge_rx    = r_st.pg_rx;
    assign o_res.purge_tx    = r_st.pg_tx;

endmodule

>>> src/telnet_com_port_receiver.sv
// Telnet COM port receiver, server side of the network-to-serial path.
// i_net carries one item per beat: func (network byte, session open, session
// close) and rx_byte. o_res carries result beats: destination (serial, network,
// status only), the byte, a last flag closing the burst of one item, and the
// line and framing status after that item.
// A parser classifies each item and hands a job to a two-entry queue; an
// emitter expands the job at one beat per cycle, while o_res.ready is high,
// into the output register. The queue and the output register lie between an
// input beat and its first result beat. Plain data and single-beat items run
// at one item per cycle while o_res.ready is high. Negotiation replies are 3
// beats, COM port replies 7 to 14, session open 35; the emitter sets the rate,
// and the queue fills and drops i_net.ready while a burst drains.
// Reset clears parsing and line flags (DTR, RTS, break low), sets the line
// mask to 00 and the modem mask to FF, and sets 115200 baud, 8 data bits,
// no parity, 1 stop bit. No clearing pass is needed. When o_res.ready is low
// the output beat holds, the queue fills, then i_net.ready drops; nothing is lost.
module telnet_com_port_receiver
    import tcpr_pkg::*;
#(
    parameter int SUB_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcpr_in_if.sink    i_net,
    tcpr_out_if.source o_res
);
    logic f_valid, f_ready, q_valid, q_pop;
    t_job f_job, q_job;

    tcpr_front #(.SUB_DEPTH(SUB_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_net       (i_net),
        .i_job_ready (f_ready),
        .o_job_valid (f_valid),
        .o_job       (f_job)
    );

    tcpr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push       (f_job),
        .o_push_ready (f_ready),
        .o_head_valid (q_valid),
        .o_head       (q_job),
        .i_pop        (q_pop)
    );

    tcpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_res       (o_res)
    );

endmodule

>>> src/tcpr_checker.sv
module tcpr_checker
    import tcpr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [1:0] i_dest,
    input logic [7:0] i_byte,
    input logic       i_last
);
    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_byte) && $stable(i_dest))
        else $error("result beat changed while stalled");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dest == D_STATUS |-> i_last && i_byte == 8'h00)
        else $error("status beat not a lone empty beat");

    a_serial_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dest == D_SERIAL |-> i_last)
        else $error("serial data beat not last");

    a_dest_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_dest == D_SERIAL || i_dest == D_NET || i_dest == D_STATUS)
        else $error("unused destination code");

endmodule

bind telnet_com_port_receiver tcpr_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_dest  (o_res.out_dest),
    .i_byte  (o_res.out_byte),
    .i_last  (o_res.out_last)
);

>>> verif/telnet_com_port_receiver_test.sv
module telnet_com_port_receiver_test;
    import tcpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int RAND_ITEMS = 450;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  dest;
        logic [7:0]  data;
        logic        last;
        logic        dtr;
        logic        rts;
        logic        brk;
        logic [31:0] baud;
        logic [3:0]  bits;
        logic [1:0]  par;
        logic [1:0]  stop;
        logic        prx;
        logic        ptx;
    } t_beat;

    typedef struct packed {
        logic [1:0] f;
        logic [7:0] b;
        logic       typed;
        logic [1:0] d;
        logic [7:0] eb;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tcpr_in_if  net_if ();
    tcpr_out_if res_if ();

    telnet_com_port_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_net   (net_if),
        .o_res   (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow state of the parser and the port
    t_parse      ps;
    logic [7:0]  pend;
    logic [7:0]  sub_buf [DEPTH];
    int          sub_cnt;
    logic        dtr, rts, brk;
    logic [7:0]  lmask, mmask;
    logic [31:0] baud;
    logic [3:0]  bits;
    logic [1:0]  par, stop;
    logic        prx, ptx;
    logic [1:0]  em_d [OPEN_LEN];
    logic [7:0]  em_b [OPEN_LEN];
    int          em_n;

    t_beat expected_beats [$];
    int    errors = 0;
    int    items_sent = 0;
    bit    calm = 1'b0;
    bit    hold_off = 1'b0;
    bit    start_hold = 1'b0;
    int    idle_cycles = 0;

    task automatic note_fail(input string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endtask

    task automatic emit(input logic [1:0] d, input logic [7:0] b);
        if (em_n < OPEN_LEN) begin
            em_d[em_n] = d;
            em_b[em_n] = b;
            em_n++;
        end
    endtask

    task automatic send_opt(input logic [7:0] act, input logic [7:0] opt);
        emit(D_NET, T_IAC);
        emit(D_NET, act);
        emit(D_NET, opt);
    endtask

    task automatic send_reply(input logic [7:0] code, input logic [31:0] v, input int n);
        logic [7:0] b;
        emit(D_NET, T_IAC);
        emit(D_NET, T_SB);
        emit(D_NET, OPT_COM);
        emit(D_NET, code);
        for (int i = n - 1; i >= 0; i--) begin
            b = v[i*8 +: 8];
            emit(D_NET, b);
            if (b == T_IAC) emit(D_NET, T_IAC);
        end
        emit(D_NET, T_IAC);
        emit(D_NET, T_SE);
    endtask

    task automatic set_control(input logic [7:0] v);
        logic [7:0] r;
        case (v)
            8'd0, 8'd1, 8'd2, 8'd3: r = 8'd1;
            8'd4: r = brk ? 8'd5 : 8'd6;
            8'd5: begin brk = 1'b1; r = 8'd5; end
            8'd6: begin brk = 1'b0; r = 8'd6; end
            8'd7: r = dtr ? 8'd8 : 8'd9;
            8'd8: begin dtr = 1'b1; r = 8'd8; end
            8'd9: begin dtr = 1'b0; r = 8'd9; end
            8'd10: r = rts ? 8'd11 : 8'd12;
            8'd11: begin rts = 1'b1; r = 8'd11; end
            8'd12: begin rts = 1'b0; r = 8'd12; end
            default: return;
        endcase
        send_reply(C_CONTROL + REPLY_OFS, 32'(r), 1);
    endtask

    task automatic apply_command();
        logic [7:0]  a;
        logic [31:0] br;
        if (sub_cnt < 2 || sub_buf[0] != OPT_COM) return;
        a = (sub_cnt >= 3) ? sub_buf[2] : 8'h00;
        case (sub_buf[1])
            C_BAUD: begin
                if (sub_cnt >= 6) begin
                    br = {sub_buf[2], sub_buf[3], sub_buf[4], sub_buf[5]};
                    if (br != 0) begin
                        baud = br;
                        prx = 1'b1;
                        ptx = 1'b1;
                    end
                end
                send_reply(C_BAUD + REPLY_OFS, baud, 4);
            end
            C_DSIZE: begin
                if (sub_cnt >= 3 && a >= 5 && a <= 8) begin
                    bits = a[3:0];
                    prx = 1'b1;
                    ptx = 1'b1;
                end
                send_reply(C_DSIZE + REPLY_OFS, 32'(bits), 1);
            end
            C_PARITY: begin
                if (sub_cnt >= 3 && a >= 1 && a <= 3) begin
                    par = a[1:0];
                    prx = 1'b1;
                    ptx = 1'b1;
                end
                send_reply(C_PARITY + REPLY_OFS, 32'(par), 1);
            end
            C_STOP: begin
                if (sub_cnt >= 3 && (a == 1 || a == 2)) begin
                    stop = a[1:0];
                    prx = 1'b1;
                    ptx = 1'b1;
                end
                send_reply(C_STOP + REPLY_OFS, 32'(stop), 1);
            end
            C_CONTROL: if (sub_cnt >= 3) set_control(a);
            C_NOTIFY: send_reply(C_NOTIFY + REPLY_OFS, 0, 1);
            C_FLOW: send_reply(C_FLOW + REPLY_OFS, 0, 1);
            C_LMASK: begin
                if (sub_cnt >= 3) lmask = a;
                send_reply(C_LMASK + REPLY_OFS, 32'(lmask), 1);
            end
            C_MMASK: begin
                if (sub_cnt >= 3) mmask = a;
                send_reply(C_MMASK + REPLY_OFS, 32'(mmask), 1);
            end
            C_PURGE: if (sub_cnt >= 3) begin
                if (a == 1 || a == 3) prx = 1'b1;
                if (a == 2 || a == 3) ptx = 1'b1;
                send_reply(C_PURGE + REPLY_OFS, 32'(a), 1);
            end
            default: ;
        endcase
    endtask

    task automatic sub_push(input logic [7:0] v);
        if (sub_cnt < DEPTH) begin
            sub_buf[sub_cnt] = v;
            sub_cnt++;
        end
    endtask

    task automatic reset_parse();
        ps = PS_NORMAL;
        pend = 8'h00;
        sub_cnt = 0;
    endtask

    task automatic parse_byte(input logic [7:0] v);
        case (ps)
            PS_IAC: begin
                if (v == T_IAC) begin
                    emit(D_SERIAL, T_IAC);
                    ps = PS_NORMAL;
                end else if (v == T_DO || v == T_DONT || v == T_WILL || v == T_WONT) begin
                    pend = v;
                    ps = PS_NEG;
                end else if (v == T_SB) begin
                    sub_cnt = 0;
                    ps = PS_SUB;
                end else begin
                    ps = PS_NORMAL;
                end
            end
            PS_NEG: begin
                if (pend == T_DO)
                    send_opt((v == 0 || v == 1 || v == 3 || v == OPT_COM) ? T_WILL : T_WONT, v);
                else if (pend == T_DONT)
                    send_opt(T_WONT, v);
                else if (pend == T_WILL)
                    send_opt((v == 0 || v == 3 || v == OPT_COM) ? T_DO : T_DONT, v);
                else if (pend == T_WONT)
                    send_opt(T_DONT, v);
                ps = PS_NORMAL;
            end
            PS_SUB: begin
                if (v == T_IAC) ps = PS_SUBIAC;
                else sub_push(v);
            end
            PS_SUBIAC: begin
                if (v == T_IAC) begin
                    sub_push(v);
                    ps = PS_SUB;
                end else begin
                    if (v == T_SE) apply_command();
                    ps = PS_NORMAL;
                end
            end
            default: begin
                if (v == T_IAC) ps = PS_IAC;
                else emit(D_SERIAL, v);
            end
        endcase
    endtask

    task automatic predict_beats(input logic [1:0] f, input logic [7:0] v);
        t_beat r;
        em_n = 0;
        prx = 1'b0;
        ptx = 1'b0;
        case (f)
            F_BYTE: parse_byte(v);
            F_OPEN: begin
                reset_parse();
                prx = 1'b1;
                ptx = 1'b1;
                send_opt(T_WILL, 8'h01);
                send_opt(T_WILL, 8'h03);
                send_opt(T_DO, 8'h03);
                send_opt(T_WILL, 8'h00);
                send_opt(T_DO, 8'h00);
                send_opt(T_WILL, OPT_COM);
                send_opt(T_DO, OPT_COM);
                send_reply(C_NOTIFY + REPLY_OFS, 0, 1);
                send_reply(C_FLOW + REPLY_OFS, 0, 1);
            end
            F_CLOSE: begin
                reset_parse();
                dtr = 1'b0;
                rts = 1'b0;
                prx = 1'b1;
                ptx = 1'b1;
            end
            default: ;
        endcase
        if (em_n == 0) emit(D_STATUS, 8'h00);
        for (int k = 0; k < em_n; k++) begin
            r.dest = em_d[k];
            r.data = em_b[k];
            r.last = (k == em_n - 1);
            r.dtr = dtr;
            r.rts = rts;
            r.brk = brk;
            r.baud = baud;
            r.bits = bits;
            r.par = par;
            r.stop = stop;
            r.prx = prx;
            r.ptx = ptx;
            expected_beats.push_back(r);
        end
    endtask

    task automatic send_item(input logic [1:0] f, input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 7);
            net_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        net_if.valid <= 1'b1;
        net_if.func <= f;
        net_if.rx_byte <= b;
        @(posedge i_clk);
        while (!net_if.ready) @(posedge i_clk);
        predict_beats(f, b);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_data(input logic [7:0] b);
        send_item(F_BYTE, b);
    endtask

    // value byte inside a subnegotiation, doubled when it is IAC
    task automatic send_escaped(input logic [7:0] b);
        send_data(b);
        if (b == T_IAC) send_data(T_IAC);
    endtask

    task automatic send_command();
        logic [7:0] code, v;
        int n, sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0: code = C_BAUD;   1: code = C_DSIZE;  2: code = C_PARITY;
            3: code = C_STOP;   4: code = C_CONTROL; 5: code = C_NOTIFY;
            6: code = C_FLOW;   7: code = C_LMASK;  8: code = C_MMASK;
            9: code = C_PURGE;  10: code = C_CONTROL;
            default: code = 8'($urandom_range(0, 255));
        endcase
        send_data(T_IAC);
        send_data(T_SB);
        send_escaped(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : OPT_COM);
        if ($urandom_range(0, 15) != 0) begin
            send_escaped(code);
            if (code == C_BAUD) n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : 4;
            else n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 1;
            if ($urandom_range(0, 19) == 0) n = $urandom_range(15, 20);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0: v = 8'($urandom_range(0, 255));
                    1: v = ($urandom_range(0, 1) != 0) ? T_IAC : 8'h00;
                    default: v = 8'($urandom_range(0, 13));
                endcase
                send_escaped(v);
            end
        end
        send_data(T_IAC);
        // rarely abandon it with a stray byte
        send_data(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 254)) : T_SE);
    endtask

    task automatic send_random_sequence();
        logic [7:0] neg [4];
        neg = '{T_DO, T_DONT, T_WILL, T_WONT};
        case ($urandom_range(0, 9))
            0, 1: send_data(8'($urandom_range(0, 254)));
            2: begin send_data(T_IAC); send_data(T_IAC); end
            3: begin
                send_data(T_IAC);
                send_data(neg[$urandom_range(0, 3)]);
                send_data(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 4)) :
                          (($urandom_range(0, 1) != 0) ? OPT_COM :
                           8'($urandom_range(0, 255))));
            end
            4, 5, 6: send_command();
            7: send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            8: begin send_data(T_IAC); send_data(8'($urandom_range(0, 255))); end
            default: send_item(($urandom_range(0, 1) != 0) ? F_OPEN : F_CLOSE,
                               8'($urandom_range(0, 255)));
        endcase
    endtask

    t_row script [] = '{
        '{F_BYTE, 8'h00, 1'b1, D_SERIAL, 8'h00},
        '{F_BYTE, 8'hFE, 1'b1, D_SERIAL, 8'hFE},
        '{F_BYTE, T_IAC, 1'b1, D_STATUS, 8'h00},
        '{F_BYTE, T_IAC, 1'b1, D_SERIAL, T_IAC},
        '{F_BYTE, T_IAC, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, T_DO,  1'b0, D_STATUS, 8'h00},
        '{F_BYTE, OPT_COM, 1'b1, D_NET, T_IAC},
        '{F_BYTE, T_IAC, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, T_WILL, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, 8'h05, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, T_IAC, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, T_DONT, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, 8'h01, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, T_IAC, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, 8'h01, 1'b1, D_STATUS, 8'h00},
        '{F_BYTE, T_IAC, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, T_SB,  1'b0, D_STATUS, 8'h00},
        '{F_BYTE, OPT_COM, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, C_PURGE, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, 8'h03, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, T_IAC, 1'b0, D_STATUS, 8'h00},
        '{F_BYTE, T_SE,  1'b1, D_NET, T_IAC},
        '{F_OPEN, 8'hFF, 1'b1, D_NET, T_IAC},
        '{F_CLOSE, 8'h00, 1'b1, D_STATUS, 8'h00},
        '{2'd3, 8'hFF, 1'b1, D_STATUS, 8'h00}
    };

    // receiver side
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            res_if.ready <= 1'b0;
        end else if (calm) begin
            res_if.ready <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            res_if.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(0, 6);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // long receiver hold-off, while the sender keeps offering items
    initial begin
        wait (start_hold);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        t_beat got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.out_dest, res_if.out_byte, res_if.out_last, res_if.dtr_on,
                    res_if.rts_on, res_if.break_on, res_if.baud_rate, res_if.data_bits,
                    res_if.parity_code, res_if.stop_bits, res_if.purge_rx, res_if.purge_tx};
            if (expected_beats.size() == 0) begin
                note_fail($sformatf("unexpected beat %h", got));
            end else begin
                want = expected_beats.pop_front();
                if (got !== want)
                    note_fail($sformatf("expected %h got %h", want, got));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((net_if.valid && net_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("[telnet_com_port_receiver] ERROR");
            $finish;
        end
    end

    initial begin
        int idx, base;
        net_if.valid = 1'b0;
        net_if.func = F_BYTE;
        net_if.rx_byte = 8'h00;
        res_if.ready = 1'b0;
        reset_parse();
        dtr = 1'b0;
        rts = 1'b0;
        brk = 1'b0;
        lmask = 8'h00;
        mmask = 8'hFF;
        baud = 32'd115200;
        bits = 4'd8;
        par = 2'd1;
        stop = 2'd1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[i]) begin
            send_item(script[i].f, script[i].b);
            // the beats of this item sit at the tail of the queue
            base = expected_beats.size() - em_n;
            if (script[i].typed && (expected_beats[base].dest !== script[i].d ||
                                    expected_beats[base].data !== script[i].eb))
                note_fail($sformatf("row %0d: typed %0d/%h, predicted %0d/%h", i,
                          script[i].d, script[i].eb, expected_beats[base].dest,
                          expected_beats[base].data));
        end

        base = items_sent;
        while (items_sent < base + RAND_ITEMS) begin
            idx = items_sent - base;
            if (idx > 150 && !start_hold) begin
                // open a session under the hold-off so the burst backs up
                start_hold = 1'b1;
                send_item(F_OPEN, 8'h00);
            end
            if (idx > RAND_ITEMS - 60) calm = 1'b1;
            send_random_sequence();
        end
        net_if.valid <= 1'b0;

        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_beats.size() == 0)
            $display("[telnet_com_port_receiver] OK");
        else
            $display("[telnet_com_port_receiver] ERROR");
        $finish;
    end

endmodule
